// ===== hw/rtl/damage_rect_tracker_assert.svh =====
// assertion macros used by the damage tracker checker
`ifndef DAMAGE_RECT_TRACKER_ASSERT_SVH
`define DAMAGE_RECT_TRACKER_ASSERT_SVH

// same-cycle implication
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("damage tracker check failed");

// next-cycle implication
`define DRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("damage tracker check failed");

`endif

// ===== hw/rtl/drt_pkg.sv =====
// types, constants and microcode table of the damage rectangle tracker
package drt_pkg;

  localparam int MAX_REGIONS  = 32;
  localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int SCREEN_LIMIT = 4096;
  localparam int CLIP_W       = 18;
  localparam int POS_W        = 12;
  localparam int SIZE_W       = 13;
  localparam int RECT_W       = 16;

  localparam logic [CFG_W-1:0] SCREEN_W_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0] SCREEN_H_RST = CFG_W'(768);

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_MARK,
    REQ_CLEAR,
    REQ_PRESENT
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_LO,
    S_ADD_HI,
    S_ADD_COMMIT,
    S_MARK,
    S_CLEAR,
    S_PRESENT,
    S_EMIT_FULL,
    S_EMIT_REGION
  } step_t;

  typedef enum logic [3:0] {
    UOP_LOAD,
    UOP_CLIP_LO,
    UOP_CLIP_HI,
    UOP_COMMIT,
    UOP_MARK,
    UOP_CLEAR,
    UOP_PRES_START,
    UOP_EMIT_FULL,
    UOP_EMIT_REGION
  } uop_t;

  typedef enum logic [2:0] {
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_PRESENT,
    JMP_SLOT,
    JMP_LAST
  } jmp_t;

  typedef struct packed {
    logic  accept;
    uop_t  uop;
    jmp_t  jmp;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } region_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    case (step)
      S_IDLE:        cw = '{1'b1, UOP_LOAD,        JMP_DISPATCH, S_IDLE};
      S_ADD_LO:      cw = '{1'b0, UOP_CLIP_LO,     JMP_GOTO,     S_ADD_HI};
      S_ADD_HI:      cw = '{1'b0, UOP_CLIP_HI,     JMP_GOTO,     S_ADD_COMMIT};
      S_ADD_COMMIT:  cw = '{1'b0, UOP_COMMIT,      JMP_GOTO,     S_IDLE};
      S_MARK:        cw = '{1'b0, UOP_MARK,        JMP_GOTO,     S_IDLE};
      S_CLEAR:       cw = '{1'b0, UOP_CLEAR,       JMP_GOTO,     S_IDLE};
      S_PRESENT:     cw = '{1'b0, UOP_PRES_START,  JMP_PRESENT,  S_IDLE};
      S_EMIT_FULL:   cw = '{1'b0, UOP_EMIT_FULL,   JMP_SLOT,     S_IDLE};
      S_EMIT_REGION: cw = '{1'b0, UOP_EMIT_REGION, JMP_LAST,     S_IDLE};
      default:       cw = '{1'b0, UOP_CLEAR,       JMP_GOTO,     S_IDLE};
    endcase
    return cw;
  endfunction

  function automatic step_t dispatch(input req_t req);
    step_t s;
    case (req)
      REQ_ADD:     s = S_ADD_LO;
      REQ_MARK:    s = S_MARK;
      REQ_CLEAR:   s = S_CLEAR;
      REQ_PRESENT: s = S_PRESENT;
      default:     s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/drt_req_if.sv =====
// request channel of the damage rectangle tracker
interface drt_req_if import drt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  req_t                     req_type;
  logic signed [RECT_W-1:0] rect_x;
  logic signed [RECT_W-1:0] rect_y;
  logic signed [RECT_W-1:0] rect_w;
  logic signed [RECT_W-1:0] rect_h;

  modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, req_type, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

// ===== hw/rtl/drt_rgn_if.sv =====
// region channel of the damage rectangle tracker
interface drt_rgn_if import drt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic [SIZE_W-1:0] out_w;
  logic [SIZE_W-1:0] out_h;
  logic              whole_screen;
  logic              last_region;

  modport source (output valid, out_x, out_y, out_w, out_h, whole_screen, last_region,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_w, out_h, whole_screen, last_region,
                  output ready);
endinterface

// ===== hw/rtl/damage_rect_tracker.sv =====
// damage rectangle tracker: clipped region list with full-screen fallback
//
// Requests are taken one at a time by a small microcoded sequencer that runs one control
// word per cycle. An add steps through accept, left/top clip, right/bottom clip and commit;
// mark full screen and clear list through accept and one more step; a present through accept
// and a start step, then emits the full screen if marked, else each stored region; a stalled
// result side holds the sequencer on the emit step. The region store is a 32-entry memory
// with one registered read port, which sets the drain rate of one region per cycle while the
// result side takes beats. The store needs no clearing after reset: only entries below the
// region count are emitted. The user writes screen size registers only while no request is
// in flight; the block does not enforce this. A size of 0 acts as 1, above 4096 as 4096.
module damage_rect_tracker import drt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  drt_req_if.sink              in_req,
  drt_rgn_if.source            out_rgn,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(SCREEN_LIMIT)) begin
      r = CFG_W'(SCREEN_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  step_t      step_r, step_nxt;
  ctrl_word_t cw;

  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic [CFG_W-1:0] eff_w, eff_h;

  logic signed [CLIP_W-1:0] cx_r, cy_r, cw_r, ch_r;
  logic signed [CLIP_W-1:0] cx_nxt, cy_nxt, cw_nxt, ch_nxt;
  logic signed [CLIP_W-1:0] sum_x, sum_y, sw_ext, sh_ext;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             flag_r, flag_nxt;

  region_t          mem [MAX_REGIONS];
  region_t          rd_data_r;
  region_t          mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;

  logic    out_valid_r, out_valid_nxt;
  region_t out_data_r, out_data_nxt;
  logic    out_whole_r, out_whole_nxt;
  logic    out_last_r, out_last_nxt;

  logic in_fire, slot_free, is_last, list_full, rect_ok;

  assign cw        = ucode_rom(step_r);
  assign in_fire   = cw.accept && in_req.valid;
  assign slot_free = !out_valid_r || out_rgn.ready;
  assign is_last   = (idx_r + CNT_W'(1)) == count_r;
  assign list_full = count_r >= CNT_W'(MAX_REGIONS);

  assign eff_w  = eff_size(scr_w_r);
  assign eff_h  = eff_size(scr_h_r);
  assign sw_ext = signed'({{(CLIP_W-CFG_W){1'b0}}, eff_w});
  assign sh_ext = signed'({{(CLIP_W-CFG_W){1'b0}}, eff_h});
  assign sum_x  = cx_r + cw_r;
  assign sum_y  = cy_r + ch_r;

  assign rect_ok = !cw_r[CLIP_W-1] && (cw_r != '0) && !ch_r[CLIP_W-1] && (ch_r != '0);

  assign mem_wdata = '{x: cx_r[POS_W-1:0], y: cy_r[POS_W-1:0],
                       w: cw_r[SIZE_W-1:0], h: ch_r[SIZE_W-1:0]};
  assign rd_addr   = idx_nxt[IDX_W-1:0];

  assign in_req.ready         = cw.accept;
  assign out_rgn.valid        = out_valid_r;
  assign out_rgn.out_x        = out_data_r.x;
  assign out_rgn.out_y        = out_data_r.y;
  assign out_rgn.out_w        = out_data_r.w;
  assign out_rgn.out_h        = out_data_r.h;
  assign out_rgn.whole_screen = out_whole_r;
  assign out_rgn.last_region  = out_last_r;

  // sequencer: next step
  always_comb begin
    step_nxt = step_r;
    case (cw.jmp)
      JMP_GOTO: begin
        step_nxt = cw.target;
      end
      JMP_DISPATCH: begin
        if (in_fire) step_nxt = dispatch(in_req.req_type);
      end
      JMP_PRESENT: begin
        if (flag_r) begin
          step_nxt = S_EMIT_FULL;
        end else if (count_r == '0) begin
          step_nxt = cw.target;
        end else begin
          step_nxt = S_EMIT_REGION;
        end
      end
      JMP_SLOT: begin
        if (slot_free) step_nxt = cw.target;
      end
      JMP_LAST: begin
        if (slot_free && is_last) step_nxt = cw.target;
      end
      default: begin
        step_nxt = S_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    ch_nxt        = ch_r;
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    idx_nxt       = idx_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_rgn.ready;
    out_data_nxt  = out_data_r;
    out_whole_nxt = out_whole_r;
    out_last_nxt  = out_last_r;
    case (cw.uop)
      UOP_LOAD: begin
        if (in_fire) begin
          cx_nxt = CLIP_W'(in_req.rect_x);
          cy_nxt = CLIP_W'(in_req.rect_y);
          cw_nxt = CLIP_W'(in_req.rect_w);
          ch_nxt = CLIP_W'(in_req.rect_h);
        end
      end
      UOP_CLIP_LO: begin
        if (cx_r[CLIP_W-1]) begin
          cw_nxt = cw_r + cx_r;
          cx_nxt = '0;
        end
        if (cy_r[CLIP_W-1]) begin
          ch_nxt = ch_r + cy_r;
          cy_nxt = '0;
        end
      end
      UOP_CLIP_HI: begin
        if (sum_x > sw_ext) cw_nxt = sw_ext - cx_r;
        if (sum_y > sh_ext) ch_nxt = sh_ext - cy_r;
      end
      UOP_COMMIT: begin
        if (!flag_r && rect_ok) begin
          if (list_full) begin
            flag_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      UOP_MARK: begin
        flag_nxt = 1'b1;
      end
      UOP_CLEAR: begin
        count_nxt = '0;
        flag_nxt  = 1'b0;
      end
      UOP_PRES_START: begin
        idx_nxt = '0;
      end
      UOP_EMIT_FULL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{x: '0, y: '0, w: eff_w, h: eff_h};
          out_whole_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          count_nxt     = '0;
          flag_nxt      = 1'b0;
        end
      end
      UOP_EMIT_REGION: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_whole_nxt = 1'b0;
          out_last_nxt  = is_last;
          idx_nxt       = idx_r + CNT_W'(1);
          if (is_last) begin
            count_nxt = '0;
            flag_nxt  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
    end else begin
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cw_r        <= cw_nxt;
    ch_r        <= ch_nxt;
    out_data_r  <= out_data_nxt;
    out_whole_r <= out_whole_nxt;
    out_last_r  <= out_last_nxt;
  end

  // region store
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[IDX_W-1:0]] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/drt_checker.sv =====
// port-level checks of the damage rectangle tracker and their binding
`include "damage_rect_tracker_assert.svh"

module drt_checker import drt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_x,
  input logic [POS_W-1:0]  out_y,
  input logic [SIZE_W-1:0] out_w,
  input logic [SIZE_W-1:0] out_h,
  input logic              out_whole,
  input logic              out_last
);

  // a stalled beat holds
  `DRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_w) && $stable(out_h) && $stable(out_whole) && $stable(out_last))

  // full-screen flip is a single region at the origin
  `DRT_ASSERT_IMP(a_whole_single, clk, rst_n, out_valid && out_whole, out_last && (out_x == '0) && (out_y == '0))

  // no empty region is ever emitted
  `DRT_ASSERT_IMP(a_nonempty, clk, rst_n, out_valid, (out_w != '0) && (out_h != '0))

  // the sequencer is busy for at least one step after taking a request
  `DRT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind damage_rect_tracker drt_checker u_drt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rgn.valid),
  .out_ready (out_rgn.ready),
  .out_x     (out_rgn.out_x),
  .out_y     (out_rgn.out_y),
  .out_w     (out_rgn.out_w),
  .out_h     (out_rgn.out_h),
  .out_whole (out_rgn.whole_screen),
  .out_last  (out_rgn.last_region)
);
